>>> hw/rtl/spr_au_pkg.sv
// package for the special-purpose register access unit
// holds transfer payload types, register numbers, status codes and defaults
// no dependencies
package spr_au_pkg;

    // payload widths
    localparam int unsigned REG_NUM_W = 10;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned STATUS_W  = 2;

    // default number of quantization registers
    localparam int unsigned QUANT_REG_COUNT_DEF = 8;

    // apb port geometry
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-1:0] ADDR_EXT_HANDLER = 3'd0;

    // operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRIV    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FORWARD = 2'd3;

    // register numbers
    localparam logic [REG_NUM_W-1:0] SPR_XER    = 10'd1;
    localparam logic [REG_NUM_W-1:0] SPR_LR     = 10'd8;
    localparam logic [REG_NUM_W-1:0] SPR_CTR    = 10'd9;
    localparam logic [REG_NUM_W-1:0] SPR_DSISR  = 10'd18;
    localparam logic [REG_NUM_W-1:0] SPR_DAR    = 10'd19;
    localparam logic [REG_NUM_W-1:0] SPR_SRR0   = 10'd26;
    localparam logic [REG_NUM_W-1:0] SPR_SRR1   = 10'd27;
    localparam logic [REG_NUM_W-1:0] SPR_TBL_RD = 10'd268;
    localparam logic [REG_NUM_W-1:0] SPR_TBU_RD = 10'd269;
    localparam logic [REG_NUM_W-1:0] SPR_EAR    = 10'd282;
    localparam logic [REG_NUM_W-1:0] SPR_TBL_WR = 10'd284;
    localparam logic [REG_NUM_W-1:0] SPR_TBU_WR = 10'd285;
    localparam logic [REG_NUM_W-1:0] SPR_PVR    = 10'd287;
    localparam logic [REG_NUM_W-1:0] SPR_GQR0   = 10'd912;
    localparam logic [REG_NUM_W-1:0] SPR_HID2   = 10'd920;

    // processor version constant
    localparam logic [DATA_W-1:0] PVR_VALUE = 32'h0008_3214;

    // input item
    typedef struct packed {
        logic                 operation;
        logic [REG_NUM_W-1:0] register_number;
        logic [DATA_W-1:0]    write_value;
        logic                 user_mode;
        logic [DATA_W-1:0]    instruction_address;
    } t_spr_in;

    // result item
    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   fault_address;
    } t_spr_out;

endpackage

>>> hw/rtl/spr_access_unit_core.sv
// top level of the special-purpose register access unit
// depends on spr_au_pkg for payload types, register numbers and status codes

// Register file for move-from/move-to special register instructions. One access
// is taken per clock unless stalled; its result is registered in r_out or, while
// r_out is held, in r_skid, and another access may follow at once. Register state
// is updated at the edge of the input transfer, so back-to-back accesses always
// see each other's writes. Throughput is bounded only by the two-entry output
// stage (result register plus skid register): the input stalls only when both
// hold a result the consumer has not taken. The external_handler_present bit at
// APB address 0 selects forwarding of unknown numbers, timebase writes and PVR
// reads; change it only while no access is in flight.
module spr_access_unit_core #(
    parameter int unsigned QUANT_REG_COUNT = spr_au_pkg::QUANT_REG_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  spr_au_pkg::t_spr_in                 i_item,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output spr_au_pkg::t_spr_out                o_result,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spr_au_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [spr_au_pkg::DATA_W-1:0]       pwdata,
    output logic [spr_au_pkg::DATA_W-1:0]       prdata,
    output logic                                pready
);

    localparam int unsigned QIDX_W = (QUANT_REG_COUNT > 1) ? $clog2(QUANT_REG_COUNT) : 1;
    localparam int unsigned QEND_W = spr_au_pkg::REG_NUM_W + 1;
    localparam logic [QEND_W-1:0] QUANT_END =
        QEND_W'(spr_au_pkg::SPR_GQR0) + QEND_W'(QUANT_REG_COUNT);

    // configuration
    logic r_ext_handler;

    // architectural registers
    logic [spr_au_pkg::DATA_W-1:0] r_xer, r_lr, r_ctr, r_dsisr, r_dar;
    logic [spr_au_pkg::DATA_W-1:0] r_srr0, r_srr1, r_ear, r_hid2, r_tbl, r_tbu;
    logic [spr_au_pkg::DATA_W-1:0] r_gqr [QUANT_REG_COUNT];

    // output stage
    logic                 r_out_valid, r_skid_valid;
    spr_au_pkg::t_spr_out r_out, r_skid;

    logic                 in_xfer, out_xfer, cfg_wr;
    logic                 is_basic, is_quant, priv, hit, do_write;
    logic [QIDX_W-1:0]    qidx;
    logic [spr_au_pkg::DATA_W-1:0] rd_val;
    spr_au_pkg::t_spr_out n_result;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;
    assign o_stall  = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // apb access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == spr_au_pkg::ADDR_EXT_HANDLER) ?
                    {{(spr_au_pkg::DATA_W-1){1'b0}}, r_ext_handler} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_handler <= 1'b0;
        end else if (cfg_wr && paddr == spr_au_pkg::ADDR_EXT_HANDLER) begin
            r_ext_handler <= pwdata[0];
        end
    end

    // decode of the register number
    assign is_basic = (i_item.register_number == spr_au_pkg::SPR_XER) ||
                      (i_item.register_number == spr_au_pkg::SPR_LR)  ||
                      (i_item.register_number == spr_au_pkg::SPR_CTR);
    assign is_quant = (i_item.register_number >= spr_au_pkg::SPR_GQR0) &&
                      ({1'b0, i_item.register_number} < QUANT_END);
    // quant base has its low bits clear, so the offset is the low bits
    assign qidx = i_item.register_number[QIDX_W-1:0];

    // user mode may touch the basic set, and read both timebase halves
    assign priv = i_item.user_mode && !is_basic &&
                  (i_item.operation == spr_au_pkg::OP_WRITE ||
                   (i_item.register_number != spr_au_pkg::SPR_TBL_RD &&
                    i_item.register_number != spr_au_pkg::SPR_TBU_RD));

    // register lookup: hit means the access completes locally
    always_comb begin
        hit    = 1'b1;
        rd_val = '0;
        if (i_item.operation == spr_au_pkg::OP_READ) begin
            case (i_item.register_number)
                spr_au_pkg::SPR_XER:    rd_val = r_xer;
                spr_au_pkg::SPR_LR:     rd_val = r_lr;
                spr_au_pkg::SPR_CTR:    rd_val = r_ctr;
                spr_au_pkg::SPR_DSISR:  rd_val = r_dsisr;
                spr_au_pkg::SPR_DAR:    rd_val = r_dar;
                spr_au_pkg::SPR_SRR0:   rd_val = r_srr0;
                spr_au_pkg::SPR_SRR1:   rd_val = r_srr1;
                spr_au_pkg::SPR_TBL_RD: rd_val = r_tbl;
                spr_au_pkg::SPR_TBU_RD: rd_val = r_tbu;
                spr_au_pkg::SPR_EAR:    rd_val = r_ear;
                spr_au_pkg::SPR_HID2:   rd_val = r_hid2;
                spr_au_pkg::SPR_PVR: begin
                    hit    = !r_ext_handler;
                    rd_val = spr_au_pkg::PVR_VALUE;
                end
                default: begin
                    hit    = is_quant;
                    rd_val = r_gqr[qidx];
                end
            endcase
        end else begin
            case (i_item.register_number)
                spr_au_pkg::SPR_XER,
                spr_au_pkg::SPR_LR,
                spr_au_pkg::SPR_CTR,
                spr_au_pkg::SPR_DSISR,
                spr_au_pkg::SPR_DAR,
                spr_au_pkg::SPR_SRR0,
                spr_au_pkg::SPR_SRR1,
                spr_au_pkg::SPR_EAR,
                spr_au_pkg::SPR_HID2:   hit = 1'b1;
                spr_au_pkg::SPR_TBL_WR,
                spr_au_pkg::SPR_TBU_WR: hit = !r_ext_handler;
                default:                hit = is_quant;
            endcase
        end
    end

    // result assembly
    always_comb begin
        n_result = '0;
        if (priv) begin
            n_result.status = spr_au_pkg::ST_PRIV;
        end else if (hit) begin
            n_result.status = spr_au_pkg::ST_DONE;
        end else if (r_ext_handler) begin
            n_result.status = spr_au_pkg::ST_FORWARD;
        end else begin
            n_result.status = spr_au_pkg::ST_ILLEGAL;
        end
        if (n_result.status == spr_au_pkg::ST_DONE) begin
            if (i_item.operation == spr_au_pkg::OP_READ) begin
                n_result.read_data = rd_val;
            end
        end else begin
            n_result.fault_address = i_item.instruction_address;
        end
    end

    assign do_write = in_xfer && i_item.operation == spr_au_pkg::OP_WRITE &&
                      !priv && hit;

    // register updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xer   <= '0;
            r_lr    <= '0;
            r_ctr   <= '0;
            r_dsisr <= '0;
            r_dar   <= '0;
            r_srr0  <= '0;
            r_srr1  <= '0;
            r_ear   <= '0;
            r_hid2  <= '0;
            r_tbl   <= '0;
            r_tbu   <= '0;
            for (int i = 0; i < QUANT_REG_COUNT; i++) begin
                r_gqr[i] <= '0;
            end
        end else if (do_write) begin
            case (i_item.register_number)
                spr_au_pkg::SPR_XER:    r_xer   <= i_item.write_value;
                spr_au_pkg::SPR_LR:     r_lr    <= i_item.write_value;
                spr_au_pkg::SPR_CTR:    r_ctr   <= i_item.write_value;
                spr_au_pkg::SPR_DSISR:  r_dsisr <= i_item.write_value;
                spr_au_pkg::SPR_DAR:    r_dar   <= i_item.write_value;
                spr_au_pkg::SPR_SRR0:   r_srr0  <= i_item.write_value;
                spr_au_pkg::SPR_SRR1:   r_srr1  <= i_item.write_value;
                spr_au_pkg::SPR_EAR:    r_ear   <= i_item.write_value;
                spr_au_pkg::SPR_HID2:   r_hid2  <= i_item.write_value;
                spr_au_pkg::SPR_TBL_WR: r_tbl   <= i_item.write_value;
                spr_au_pkg::SPR_TBU_WR: r_tbu   <= i_item.write_value;
                default:                r_gqr[qidx] <= i_item.write_value;
            endcase
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_xfer) begin
                r_out_valid  <= r_skid_valid || in_xfer;
                r_skid_valid <= 1'b0;
            end else if (in_xfer) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_xfer) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (in_xfer && r_out_valid && !out_xfer) begin
            r_skid <= n_result;
        end
    end

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    a_done_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == spr_au_pkg::ST_DONE) |-> o_result.fault_address == '0)
        else $error("completed access reports a fault address");

    a_fault_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != spr_au_pkg::ST_DONE) |-> o_result.read_data == '0)
        else $error("faulted or forwarded access returns data");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output stage not empty after reset");

endmodule

>>> verif/tb_spr_access_unit_core.sv
// self-checking testbench for the special-purpose register access unit
// holds a scoreboard class with its own register file model, drivers and a watchdog
// depends on spr_au_pkg and spr_access_unit_core
module tb_spr_access_unit_core;
    timeunit 1ns;
    timeprecision 1ps;

    import spr_au_pkg::*;

    localparam int unsigned NQ          = QUANT_REG_COUNT_DEF;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          PHASE_ITEMS = 230;
    localparam int          NUM_PHASES  = 6;

    // register file model and store of predicted results
    class spr_scoreboard;
        bit                handler_on;
        logic [DATA_W-1:0] xer, lr, ctr, dsisr, dar, srr0, srr1, ear, hid2;
        logic [DATA_W-1:0] gqr [NQ];
        logic [63:0]       tbase;
        t_spr_out          pending [$];
        int                mismatch_count;
        int                reads_seen;
        int                writes_seen;
        int                status_seen [4];

        function new();
            handler_on = 1'b0;
            xer = '0; lr = '0; ctr = '0; dsisr = '0; dar = '0;
            srr0 = '0; srr1 = '0; ear = '0; hid2 = '0;
            foreach (gqr[i]) gqr[i] = '0;
            tbase = '0;
            mismatch_count = 0;
            reads_seen = 0;
            writes_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function bit is_gqr(logic [REG_NUM_W-1:0] n);
            return (n >= SPR_GQR0) && (int'(n) < int'(SPR_GQR0) + NQ);
        endfunction

        // move-from: status, and the value when done
        function logic [STATUS_W-1:0] fetch_reg(input logic [REG_NUM_W-1:0] n,
                                               output logic [DATA_W-1:0] d);
            d = '0;
            case (n)
                SPR_XER:    begin d = xer;   return ST_DONE; end
                SPR_LR:     begin d = lr;    return ST_DONE; end
                SPR_CTR:    begin d = ctr;   return ST_DONE; end
                SPR_DSISR:  begin d = dsisr; return ST_DONE; end
                SPR_DAR:    begin d = dar;   return ST_DONE; end
                SPR_SRR0:   begin d = srr0;  return ST_DONE; end
                SPR_SRR1:   begin d = srr1;  return ST_DONE; end
                SPR_TBL_RD: begin d = tbase[31:0];  return ST_DONE; end
                SPR_TBU_RD: begin d = tbase[63:32]; return ST_DONE; end
                SPR_EAR:    begin d = ear;   return ST_DONE; end
                SPR_PVR: begin
                    if (handler_on) return ST_FORWARD;
                    d = PVR_VALUE;
                    return ST_DONE;
                end
                SPR_HID2:   begin d = hid2;  return ST_DONE; end
                default: ;
            endcase
            if (is_gqr(n)) begin
                d = gqr[int'(n - SPR_GQR0) % NQ];
                return ST_DONE;
            end
            return handler_on ? ST_FORWARD : ST_ILLEGAL;
        endfunction

        // move-to: status, state updated when done
        function logic [STATUS_W-1:0] store_reg(logic [REG_NUM_W-1:0] n,
                                               logic [DATA_W-1:0] v);
            case (n)
                SPR_XER:   begin xer = v;   return ST_DONE; end
                SPR_LR:    begin lr = v;    return ST_DONE; end
                SPR_CTR:   begin ctr = v;   return ST_DONE; end
                SPR_DSISR: begin dsisr = v; return ST_DONE; end
                SPR_DAR:   begin dar = v;   return ST_DONE; end
                SPR_SRR0:  begin srr0 = v;  return ST_DONE; end
                SPR_SRR1:  begin srr1 = v;  return ST_DONE; end
                SPR_EAR:   begin ear = v;   return ST_DONE; end
                SPR_TBL_WR: begin
                    if (handler_on) return ST_FORWARD;
                    tbase[31:0] = v;
                    return ST_DONE;
                end
                SPR_TBU_WR: begin
                    if (handler_on) return ST_FORWARD;
                    tbase[63:32] = v;
                    return ST_DONE;
                end
                SPR_HID2:  begin hid2 = v;  return ST_DONE; end
                default: ;
            endcase
            if (is_gqr(n)) begin
                gqr[int'(n - SPR_GQR0) % NQ] = v;
                return ST_DONE;
            end
            return handler_on ? ST_FORWARD : ST_ILLEGAL;
        endfunction

        // predict the result of one accepted access
        function void note_access(t_spr_in it);
            t_spr_out            r;
            logic [STATUS_W-1:0] st;
            logic [DATA_W-1:0]   d;
            logic                basic;
            logic [REG_NUM_W-1:0] n;
            n = it.register_number;
            d = '0;
            basic = (n == SPR_XER) || (n == SPR_LR) || (n == SPR_CTR);
            if (it.operation == OP_WRITE) begin
                writes_seen++;
                if (it.user_mode && !basic) st = ST_PRIV;
                else st = store_reg(n, it.write_value);
            end else begin
                reads_seen++;
                if (it.user_mode && !basic && n != SPR_TBL_RD && n != SPR_TBU_RD)
                    st = ST_PRIV;
                else
                    st = fetch_reg(n, d);
            end
            if (st != ST_DONE) d = '0;
            r.read_data     = d;
            r.status        = st;
            r.fault_address = (st != ST_DONE) ? it.instruction_address : '0;
            status_seen[st]++;
            pending.push_back(r);
        endfunction

        // compare one result transfer with the oldest prediction
        function void check_result(t_spr_out got);
            t_spr_out want;
            if (pending.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result data=%h status=%0d addr=%h",
                             $realtime, got.read_data, got.status, got.fault_address);
                return;
            end
            want = pending.pop_front();
            if (got.read_data !== want.read_data || got.status !== want.status ||
                got.fault_address !== want.fault_address) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"%0t: mismatch exp data=%h status=%0d addr=%h, ",
                              "got data=%h status=%0d addr=%h"},
                             $realtime, want.read_data, want.status, want.fault_address,
                             got.read_data, got.status, got.fault_address);
            end
        endfunction
    endclass

    // block signals, inputs all known from time zero
    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_spr_in               i_item  = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_spr_out              o_result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0]     pwdata  = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    spr_scoreboard sb;
    bit            send_idle = 1'b1;
    bit            recv_idle = 1'b1;

    // implemented numbers outside the quantization range
    logic [REG_NUM_W-1:0] spr_known [13] = '{SPR_XER, SPR_LR, SPR_CTR, SPR_DSISR, SPR_DAR,
        SPR_SRR0, SPR_SRR1, SPR_TBL_RD, SPR_TBU_RD, SPR_EAR, SPR_TBL_WR, SPR_TBU_WR, SPR_PVR};

    spr_access_unit_core #(.QUANT_REG_COUNT(NQ)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function t_spr_in mk(logic op, logic [REG_NUM_W-1:0] n, logic [DATA_W-1:0] v,
                         logic user, logic [DATA_W-1:0] cia);
        t_spr_in it;
        it.operation           = op;
        it.register_number     = n;
        it.write_value         = v;
        it.user_mode           = user;
        it.instruction_address = cia;
        return it;
    endfunction

    // random access, mostly to implemented numbers
    function t_spr_in rand_access();
        int               k;
        logic [DATA_W-1:0] v;
        logic [REG_NUM_W-1:0] n;
        k = $urandom_range(0, 9);
        if (k < 3) n = 10'($urandom_range(0, 1023));
        else if (k < 7) n = spr_known[$urandom_range(0, 12)];
        else n = SPR_GQR0 + 10'($urandom_range(0, 8));
        k = $urandom_range(0, 9);
        v = (k == 0) ? '0 : (k == 1) ? '1 : DATA_W'($urandom());
        return mk(1'($urandom_range(0, 1)), n, v, $urandom_range(0, 9) < 3,
                  DATA_W'($urandom()));
    endfunction

    // one input transfer, after a random gap when send_idle is set
    task push_item(t_spr_in it);
        int gap;
        gap = send_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        sb.note_access(it);
    endtask

    // result side with a random stall before each transfer when recv_idle is set
    task take_results();
        int n;
        forever begin
            n = recv_idle ? $urandom_range(0, 15) : 0;
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            sb.check_result(o_result);
        end
    endtask

    // apb write: setup then access phase
    task apb_write(logic [APB_ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // sender holds off until every predicted result has come, then settles
    task drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task set_handler(bit h);
        logic [DATA_W-1:0] w;
        w    = DATA_W'($urandom());
        w[0] = h;
        apb_write(ADDR_EXT_HANDLER, w);
        sb.handler_on = h;
        // read back the flag once the write has landed
        @(posedge i_clk);
        if (prdata !== {{(DATA_W-1){1'b0}}, h}) begin
            sb.mismatch_count++;
            if (sb.mismatch_count <= 10)
                $display("%0t: handler readback exp %0d got %h", $realtime, h, prdata);
        end
    endtask

    // watchdog on cycles with no transfer on either channel
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle = 0;
            else idle++;
        end
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb_spr_access_unit_core NOT OK");
        $finish;
    end

    // stimulus and final verdict
    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            take_results();
        join_none
        @(posedge i_clk);
        set_handler(1'b0);

        // directed: field extremes, privilege, timebase, pvr, quantization, unknowns
        push_item(mk(OP_WRITE, SPR_XER, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000));
        push_item(mk(OP_READ, SPR_XER, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF));
        push_item(mk(OP_WRITE, SPR_LR, 32'h0000_0000, 1'b1, 32'h0000_0100));
        push_item(mk(OP_WRITE, SPR_CTR, 32'hA5A5_5A5A, 1'b1, 32'h0000_0104));
        push_item(mk(OP_READ, SPR_CTR, 32'hFFFF_FFFF, 1'b0, 32'h0000_0108));
        push_item(mk(OP_WRITE, SPR_DSISR, 32'h0000_1234, 1'b1, 32'hFFFF_FFFC));
        push_item(mk(OP_READ, SPR_SRR0, 32'h0000_0000, 1'b1, 32'h8000_0000));
        push_item(mk(OP_READ, SPR_TBL_RD, 32'h0000_0000, 1'b1, 32'h0000_0200));
        push_item(mk(OP_WRITE, SPR_TBL_WR, 32'hDEAD_BEEF, 1'b0, 32'h0000_0204));
        push_item(mk(OP_WRITE, SPR_TBU_WR, 32'h1234_5678, 1'b0, 32'h0000_0208));
        push_item(mk(OP_WRITE, SPR_TBU_WR, 32'h0000_0001, 1'b1, 32'h0000_020C));
        push_item(mk(OP_READ, SPR_TBL_RD, 32'h0000_0000, 1'b1, 32'h0000_0210));
        push_item(mk(OP_READ, SPR_TBU_RD, 32'h0000_0000, 1'b1, 32'h0000_0214));
        push_item(mk(OP_READ, SPR_TBL_WR, 32'h0000_0000, 1'b0, 32'h0000_0218));
        push_item(mk(OP_WRITE, SPR_TBU_RD, 32'h5555_5555, 1'b0, 32'h0000_021C));
        push_item(mk(OP_READ, SPR_PVR, 32'h0000_0000, 1'b0, 32'h0000_0220));
        push_item(mk(OP_WRITE, SPR_PVR, 32'hAAAA_AAAA, 1'b0, 32'h0000_0224));
        push_item(mk(OP_WRITE, SPR_GQR0 + 10'd7, 32'h0F0F_0F0F, 1'b0, 32'h0000_0228));
        push_item(mk(OP_READ, SPR_GQR0 + 10'd7, 32'h0000_0000, 1'b0, 32'h0000_022C));
        push_item(mk(OP_WRITE, SPR_HID2, 32'hF0F0_F0F0, 1'b0, 32'h0000_0230));
        push_item(mk(OP_READ, SPR_HID2, 32'h0000_0000, 1'b0, 32'h0000_0234));
        push_item(mk(OP_READ, 10'd1023, 32'h0000_0000, 1'b0, 32'h0000_0238));
        push_item(mk(OP_READ, 10'd0, 32'h0000_0000, 1'b0, 32'h0000_023C));

        // directed with the outside handler present
        drain();
        set_handler(1'b1);
        push_item(mk(OP_READ, SPR_PVR, 32'h0000_0000, 1'b0, 32'h0000_0300));
        push_item(mk(OP_WRITE, SPR_TBL_WR, 32'h0BAD_F00D, 1'b0, 32'h0000_0304));
        push_item(mk(OP_WRITE, 10'd1023, 32'h1111_1111, 1'b0, 32'h0000_0308));
        push_item(mk(OP_READ, 10'd1023, 32'h0000_0000, 1'b1, 32'h0000_030C));
        push_item(mk(OP_READ, SPR_TBL_RD, 32'h0000_0000, 1'b1, 32'h0000_0310));

        // random phases, each with its own handler setting and idling mix
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            set_handler((p == 1) || (p == 2) || (p == 4));
            send_idle = (p % 3) != 1;
            recv_idle = (p % 3) != 2;
            for (int i = 0; i < PHASE_ITEMS; i++)
                push_item(rand_access());
        end

        // wait out the tail
        drain();
        repeat (8) @(posedge i_clk);
        $display("covered %0d reads and %0d writes, handler off and on, gaps 0 to 15 both sides",
                 sb.reads_seen, sb.writes_seen);
        $display("status mix done %0d priv %0d illegal %0d forwarded %0d, mismatches %0d",
                 sb.status_seen[ST_DONE], sb.status_seen[ST_PRIV],
                 sb.status_seen[ST_ILLEGAL], sb.status_seen[ST_FORWARD], sb.mismatch_count);
        if (sb.mismatch_count == 0 && sb.pending.size() == 0)
            $display("tb_spr_access_unit_core OK");
        else
            $display("tb_spr_access_unit_core NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/spr_au_pkg.sv
hw/rtl/spr_access_unit_core.sv
verif/tb_spr_access_unit_core.sv
